### hdl/lfmc_pkg.sv
// Shared constants, types and table arithmetic for the linear FM chirp source.
// No dependencies; every other file in hdl/ imports this package.
package lfmc_pkg;

    localparam int DEF_PHASE_BITS      = 32;
    localparam int DEF_TABLE_ADDR_BITS = 10;
    localparam int DEF_COUNT_BITS      = 20;
    localparam int DEF_SAMPLE_BITS     = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int STEP_W      = 32;
    localparam int COUNT_CFG_W = 21;
    localparam int AMP_W       = 16;
    localparam int SAMPLE_W    = 16;
    localparam int INDEX_W     = 20;
    localparam int ROM_W       = 16;
    localparam int ROM_FRAC_BITS = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP_START = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP_DELTA = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE        = 2'd3;

    localparam logic [STEP_W-1:0]       RST_PHASE_STEP_START = 32'd0;
    localparam logic [STEP_W-1:0]       RST_PHASE_STEP_DELTA = 32'd0;
    localparam logic [COUNT_CFG_W-1:0]  RST_SAMPLE_COUNT     = 21'd1024;
    localparam logic signed [AMP_W-1:0] RST_AMPLITUDE        = 16'sd2040;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    typedef struct packed {
        logic [INDEX_W-1:0] sample_index;
        logic               chirp_last;
        logic [1:0]         quadrant;
    } sample_tag_t;

    // Q30 sine by a floored Taylor series up to x^17
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + signed'(term);
        if (sum < 64'sd0)
        begin
            sum = 64'sd0;
        end
        if (sum > signed'(ONE_Q30))
        begin
            sum = signed'(ONE_Q30);
        end
        return unsigned'(sum);
    endfunction

endpackage

### hdl/lfm_chirp_generator_core.sv
// Linear FM chirp source: phase accumulator, quarter-wave table, amplitude scaling.
// Each accepted item goes through the address, table read and output registers.
// One item per cycle unless stalled; table read and scaled sample are each registered.
// Reset (rst_n, asynchronous): registers return to their defaults, chirp to sample zero,
// pipeline empties. No clearing pass; items are taken from the first cycle after reset.
module lfm_chirp_generator_core #(
    parameter int PHASE_BITS      = lfmc_pkg::DEF_PHASE_BITS,
    parameter int TABLE_ADDR_BITS = lfmc_pkg::DEF_TABLE_ADDR_BITS,
    parameter int COUNT_BITS      = lfmc_pkg::DEF_COUNT_BITS,
    parameter int SAMPLE_BITS     = lfmc_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lfmc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lfmc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic                                 restart,
    output logic                                 sample_valid,
    input  logic                                 sample_stall,
    output logic signed [lfmc_pkg::SAMPLE_W-1:0] sample_i,
    output logic signed [lfmc_pkg::SAMPLE_W-1:0] sample_q,
    output logic [lfmc_pkg::INDEX_W-1:0]         sample_index,
    output logic                                 chirp_last
);
    import lfmc_pkg::*;

    logic [STEP_W-1:0]       step_start_reg;
    logic [STEP_W-1:0]       step_delta_reg;
    logic [COUNT_CFG_W-1:0]  sample_count_reg;
    logic signed [AMP_W-1:0] amplitude_reg;

    logic valid1_reg;
    logic valid2_reg;
    logic valid3_reg;
    logic ready1;
    logic ready2;
    logic ready3;
    logic accept;

    logic [TABLE_ADDR_BITS-1:0] table_addr;
    sample_tag_t                tag0;
    logic [TABLE_ADDR_BITS-1:0] addr1_reg;
    sample_tag_t                tag1_reg;
    sample_tag_t                tag2_reg;

    logic [TABLE_ADDR_BITS:0] addr_a;
    logic [TABLE_ADDR_BITS:0] addr_b;
    logic [ROM_W-1:0]         rom_a;
    logic [ROM_W-1:0]         rom_b;
    logic signed [ROM_W:0]    pos_a;
    logic signed [ROM_W:0]    pos_b;
    logic signed [ROM_W:0]    sin_val;
    logic signed [ROM_W:0]    cos_val;
    logic signed [SAMPLE_W-1:0] scaled_i;
    logic signed [SAMPLE_W-1:0] scaled_q;

    logic signed [SAMPLE_W-1:0] sample_i_reg;
    logic signed [SAMPLE_W-1:0] sample_q_reg;
    logic [INDEX_W-1:0]         sample_index_reg;
    logic                       chirp_last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_start_reg   <= RST_PHASE_STEP_START;
            step_delta_reg   <= RST_PHASE_STEP_DELTA;
            sample_count_reg <= RST_SAMPLE_COUNT;
            amplitude_reg    <= RST_AMPLITUDE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PHASE_STEP_START: step_start_reg   <= cfg_data;
                REG_PHASE_STEP_DELTA: step_delta_reg   <= cfg_data;
                REG_SAMPLE_COUNT:     sample_count_reg <= cfg_data[COUNT_CFG_W-1:0];
                REG_AMPLITUDE:        amplitude_reg    <= signed'(cfg_data[AMP_W-1:0]);
                default:              ;
            endcase
        end
    end

    assign ready3     = !valid3_reg || !sample_stall;
    assign ready2     = !valid2_reg || ready3;
    assign ready1     = !valid1_reg || ready2;
    assign item_stall = !ready1;
    assign accept     = item_valid && ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                valid1_reg <= accept;
            end
            if (ready2)
            begin
                valid2_reg <= valid1_reg;
            end
            if (ready3)
            begin
                valid3_reg <= valid2_reg;
            end
        end
    end

    lfmc_phase #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_phase (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .restart      (restart),
        .step_start   (step_start_reg),
        .step_delta   (step_delta_reg),
        .sample_count (sample_count_reg),
        .table_addr   (table_addr),
        .tag          (tag0)
    );

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            addr1_reg <= table_addr;
            tag1_reg  <= tag0;
        end
        if (ready2)
        begin
            tag2_reg <= tag1_reg;
        end
    end

    assign addr_a = {1'b0, addr1_reg};
    assign addr_b = ((TABLE_ADDR_BITS + 1)'(1) << TABLE_ADDR_BITS) - addr_a;

    lfmc_sine_rom #(
        .ADDR_BITS (TABLE_ADDR_BITS)
    ) u_sine_rom (
        .clk    (clk),
        .en     (ready2),
        .addr_a (addr_a),
        .addr_b (addr_b),
        .data_a (rom_a),
        .data_b (rom_b)
    );

    assign pos_a = signed'({1'b0, rom_a});
    assign pos_b = signed'({1'b0, rom_b});

    always_comb
    begin
        case (tag2_reg.quadrant)
            QUAD_0:
            begin
                sin_val = pos_a;
                cos_val = pos_b;
            end
            QUAD_1:
            begin
                sin_val = pos_b;
                cos_val = -pos_a;
            end
            QUAD_2:
            begin
                sin_val = -pos_a;
                cos_val = -pos_b;
            end
            QUAD_3:
            begin
                sin_val = -pos_b;
                cos_val = pos_a;
            end
            default:
            begin
                sin_val = pos_a;
                cos_val = pos_b;
            end
        endcase
    end

    lfmc_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale_i (
        .amplitude (amplitude_reg),
        .value     (cos_val),
        .sample    (scaled_i)
    );

    lfmc_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale_q (
        .amplitude (amplitude_reg),
        .value     (sin_val),
        .sample    (scaled_q)
    );

    always_ff @(posedge clk)
    begin
        if (ready3)
        begin
            sample_i_reg     <= scaled_i;
            sample_q_reg     <= scaled_q;
            sample_index_reg <= tag2_reg.sample_index;
            chirp_last_reg   <= tag2_reg.chirp_last;
        end
    end

    assign sample_valid = valid3_reg;
    assign sample_i     = sample_i_reg;
    assign sample_q     = sample_q_reg;
    assign sample_index = sample_index_reg;
    assign chirp_last   = chirp_last_reg;

endmodule

### hdl/lfmc_phase.sv
// Phase accumulator, phase increment and sample counter of the chirp.
// Depends on lfmc_pkg. Gives the table address and tag for the item being accepted.
module lfmc_phase #(
    parameter int PHASE_BITS      = lfmc_pkg::DEF_PHASE_BITS,
    parameter int TABLE_ADDR_BITS = lfmc_pkg::DEF_TABLE_ADDR_BITS,
    parameter int COUNT_BITS      = lfmc_pkg::DEF_COUNT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic                                restart,
    input  logic [lfmc_pkg::STEP_W-1:0]         step_start,
    input  logic [lfmc_pkg::STEP_W-1:0]         step_delta,
    input  logic [lfmc_pkg::COUNT_CFG_W-1:0]    sample_count,
    output logic [TABLE_ADDR_BITS-1:0]          table_addr,
    output lfmc_pkg::sample_tag_t               tag
);
    import lfmc_pkg::*;

    localparam int CMP_W = (COUNT_BITS + 1 > COUNT_CFG_W) ? COUNT_BITS + 1 : COUNT_CFG_W;
    localparam int TOP_W = TABLE_ADDR_BITS + 2;
    localparam logic [CMP_W-1:0] LIMIT = CMP_W'(1) << COUNT_BITS;

    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_acc_next;
    logic [PHASE_BITS-1:0] phase_step_reg;
    logic [PHASE_BITS-1:0] phase_step_next;
    logic [COUNT_BITS-1:0] counter_reg;
    logic [COUNT_BITS-1:0] counter_next;

    logic [PHASE_BITS-1:0] start_ext;
    logic [PHASE_BITS-1:0] delta_ext;
    logic [PHASE_BITS-1:0] phase_cur;
    logic [PHASE_BITS-1:0] step_cur;
    logic [COUNT_BITS-1:0] count_cur;
    logic [CMP_W-1:0]      count_ext;
    logic [CMP_W-1:0]      count_cfg_ext;
    logic [CMP_W-1:0]      count_eff;
    logic [TOP_W-1:0]      phase_top;
    logic                  last;

    assign start_ext = PHASE_BITS'(step_start);
    assign delta_ext = PHASE_BITS'(step_delta);

    assign phase_cur = restart ? '0 : phase_acc_reg;
    assign step_cur  = restart ? start_ext : phase_step_reg;
    assign count_cur = restart ? '0 : counter_reg;

    assign count_ext     = CMP_W'(count_cur);
    assign count_cfg_ext = CMP_W'(sample_count);

    always_comb
    begin
        if (count_cfg_ext == '0)
        begin
            count_eff = CMP_W'(1);
        end
        else if (count_cfg_ext > LIMIT)
        begin
            count_eff = LIMIT;
        end
        else
        begin
            count_eff = count_cfg_ext;
        end
    end

    assign last = (count_ext + CMP_W'(1)) >= count_eff;

    assign phase_top  = phase_cur[PHASE_BITS-1 -: TOP_W];
    assign table_addr = phase_top[TABLE_ADDR_BITS-1:0];

    always_comb
    begin
        tag.sample_index = count_ext[INDEX_W-1:0];
        tag.chirp_last   = last;
        tag.quadrant     = phase_top[TOP_W-1 -: 2];
    end

    always_comb
    begin
        if (last)
        begin
            phase_acc_next  = '0;
            phase_step_next = start_ext;
            counter_next    = '0;
        end
        else
        begin
            phase_acc_next  = phase_cur + step_cur;
            phase_step_next = step_cur + delta_ext;
            counter_next    = count_cur + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg  <= '0;
            phase_step_reg <= PHASE_BITS'(RST_PHASE_STEP_START);
            counter_reg    <= '0;
        end
        else if (accept)
        begin
            phase_acc_reg  <= phase_acc_next;
            phase_step_reg <= phase_step_next;
            counter_reg    <= counter_next;
        end
    end

endmodule

### hdl/lfmc_sine_rom.sv
// Quarter-wave sine table with two registered read ports.
// Depends on lfmc_pkg for the table arithmetic; contents are fixed at elaboration.
module lfmc_sine_rom #(
    parameter int ADDR_BITS = lfmc_pkg::DEF_TABLE_ADDR_BITS
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [ADDR_BITS:0]            addr_a,
    input  logic [ADDR_BITS:0]            addr_b,
    output logic [lfmc_pkg::ROM_W-1:0]    data_a,
    output logic [lfmc_pkg::ROM_W-1:0]    data_b
);
    import lfmc_pkg::*;

    localparam int DEPTH = (1 << ADDR_BITS) + 1;

    typedef logic [DEPTH-1:0][ROM_W-1:0] sine_table_t;

    function automatic sine_table_t build_table();
        sine_table_t t;
        logic [63:0] x;
        logic [63:0] v;
        for (int k = 0; k < DEPTH; k++)
        begin
            x = (HALF_PI_Q30 * 64'(k)) >> ADDR_BITS;
            v = (sin_q30(x) + 64'd16384) >> ROM_FRAC_BITS;
            if (v > 64'd32768)
            begin
                v = 64'd32768;
            end
            t[k] = v[ROM_W-1:0];
        end
        return t;
    endfunction

    localparam sine_table_t SINE_TABLE = build_table();

    logic [ROM_W-1:0] data_a_reg;
    logic [ROM_W-1:0] data_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a_reg <= SINE_TABLE[addr_a];
            data_b_reg <= SINE_TABLE[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

### hdl/lfmc_scale.sv
// Amplitude scaling of one signed table value, truncated toward zero and saturated.
// Depends on lfmc_pkg for field widths.
module lfmc_scale #(
    parameter int SAMPLE_BITS = lfmc_pkg::DEF_SAMPLE_BITS
) (
    input  logic signed [lfmc_pkg::AMP_W-1:0]    amplitude,
    input  logic signed [lfmc_pkg::ROM_W:0]      value,
    output logic signed [lfmc_pkg::SAMPLE_W-1:0] sample
);
    import lfmc_pkg::*;

    localparam int PROD_W = AMP_W + ROM_W + 1;
    localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [PROD_W-1:0] SAT_MIN = -SAT_MAX - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'((64'sd1 <<< ROM_FRAC_BITS) - 64'sd1);

    logic signed [PROD_W-1:0] product;
    logic signed [PROD_W-1:0] bias;
    logic signed [PROD_W-1:0] quotient;
    logic signed [PROD_W-1:0] clamped;

    assign product  = PROD_W'(amplitude) * PROD_W'(value);
    assign bias     = product[PROD_W-1] ? ROUND_BIAS : '0;
    assign quotient = (product + bias) >>> ROM_FRAC_BITS;

    always_comb
    begin
        if (quotient > SAT_MAX)
        begin
            clamped = SAT_MAX;
        end
        else if (quotient < SAT_MIN)
        begin
            clamped = SAT_MIN;
        end
        else
        begin
            clamped = quotient;
        end
    end

    assign sample = clamped[SAMPLE_W-1:0];

endmodule
